[rtl/stt_pkg.sv]
// Package for step_toward_target: shared types, constants and the arctangent table.
// No dependencies.
package stt_pkg;

  localparam int GUARD = 8;
  localparam int WW = 34 + GUARD + 2;     // CORDIC x/y working width
  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

  typedef enum logic [2:0] {
    ST_IDLE, ST_VEC, ST_MAG, ST_ROT_INIT, ST_ROT, ST_FINISH, ST_OUT
  } state_t;

  typedef enum logic [0:0] { OP_STEP = 1'b0, OP_LOAD = 1'b1 } op_t;

  localparam logic [0:0] REG_NEAR = 1'b0;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;      // latch item, set up vectoring
    logic vec_step;   // one vectoring iteration
    logic mag;        // form distance, snap decision
    logic rot_init;   // load rotation start vector
    logic rot_step;   // one rotation iteration
    logic finish;     // update position, form result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_load;
    logic arrived;
  } sts_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

[rtl/stt_if.sv]
// Valid/ready channel interfaces for step_toward_target.
// Depends on nothing.
interface stt_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] target_x;
  logic [31:0] target_y;
  logic [30:0] step_amount;
  modport source (output valid, op, target_x, target_y, step_amount, input ready);
  modport sink (input valid, op, target_x, target_y, step_amount, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic        arrived;
  logic [31:0] gap;
  logic [15:0] heading;
  logic        near;
  modport source (output valid, pos_x, pos_y, arrived, gap, heading, near, input ready);
  modport sink (input valid, pos_x, pos_y, arrived, gap, heading, near, output ready);
endinterface

[rtl/stt_ctrl.sv]
// Controller state machine for step_toward_target.
// Depends on stt_pkg.
module stt_ctrl #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output stt_pkg::cmd_t cmd,
  output logic [4:0]    iter,
  input  stt_pkg::sts_t sts
);

  localparam int CW = $clog2(CORDIC_STEPS + 1);

  stt_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Hold state and iteration count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stt_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign iter = 5'(cnt_r);

  // Sequence the two CORDIC passes
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      stt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = stt_pkg::ST_VEC;
        end
      end
      stt_pkg::ST_VEC: begin
        if (sts.is_load) begin
          state_nxt = stt_pkg::ST_FINISH;
        end else begin
          cmd.vec_step = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CW'(CORDIC_STEPS - 1)) state_nxt = stt_pkg::ST_MAG;
        end
      end
      stt_pkg::ST_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = stt_pkg::ST_ROT_INIT;
      end
      stt_pkg::ST_ROT_INIT: begin
        if (sts.arrived) begin
          state_nxt = stt_pkg::ST_FINISH;
        end else begin
          cmd.rot_init = 1'b1;
          cnt_nxt   = '0;
          state_nxt = stt_pkg::ST_ROT;
        end
      end
      stt_pkg::ST_ROT: begin
        cmd.rot_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(CORDIC_STEPS - 1)) state_nxt = stt_pkg::ST_FINISH;
      end
      stt_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = stt_pkg::ST_OUT;
      end
      stt_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = stt_pkg::ST_IDLE;
      end
      default: state_nxt = stt_pkg::ST_IDLE;
    endcase
  end

endmodule

[rtl/stt_dp.sv]
// Datapath for step_toward_target: position, shared CORDIC, magnitude and result.
// Depends on stt_pkg.
module stt_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  stt_pkg::cmd_t cmd,
  input  logic [4:0]    iter,
  output stt_pkg::sts_t sts,
  input  logic [31:0]   near_threshold,
  input  logic          in_op,
  input  logic [31:0]   in_target_x,
  input  logic [31:0]   in_target_y,
  input  logic [30:0]   in_step_amount,
  output logic [31:0]   pos_x,
  output logic [31:0]   pos_y,
  output logic          arrived,
  output logic [31:0]   gap,
  output logic [15:0]   heading,
  output logic          near
);

  localparam int WW = stt_pkg::WW;
  localparam int G  = stt_pkg::GUARD;

  logic signed [31:0] posx_r, posy_r;
  logic               load_r, arr_r, near_r;
  logic signed [31:0] tx_r, ty_r;
  logic [30:0]        amt_r;
  logic signed [WW-1:0] x_r, y_r;
  logic [31:0]        z_r, za_r;
  logic [31:0]        gap_r;
  logic [15:0]        head_r;

  logic signed [32:0] dx, dy;
  logic signed [WW-1:0] xs, ys, xg, yg;
  logic [31:0] at;
  logic [63:0] mag_hi, mag_lo, rot_lo;
  logic [WW-1:0] xu;
  logic [33:0] mag_dist;
  logic [63:0] rot_mag;
  logic signed [WW-1:0] rinc_x, rinc_y;
  logic signed [WW:0] sx, sy;

  assign dx = 33'(signed'(tx_r)) - 33'(posx_r);
  assign dy = 33'(signed'(ty_r)) - 33'(posy_r);
  assign xg = WW'(dx) <<< G;
  assign yg = WW'(dy) <<< G;
  assign xs = x_r >>> iter;
  assign ys = y_r >>> iter;
  assign at = stt_pkg::atan_lut(iter);

  // Magnitude: x * (1/K) rounded, then drop guard bits
  assign xu       = x_r;
  assign mag_hi   = 64'(xu[WW-1:32]) * 64'(stt_pkg::INV_GAIN);
  assign mag_lo   = 64'(xu[31:0]) * 64'(stt_pkg::INV_GAIN);
  assign mag_dist = 34'((mag_hi + ((mag_lo + 64'h80000000) >> 32) + 64'(1 << (G - 1))) >> G);

  // Rotation start magnitude: (amt << G) / K, at most 39 bits x 32
  assign rot_lo  = 64'(amt_r[23:0]) << G;
  assign rot_mag = ((64'(amt_r[30:24]) << (G - 8)) * 64'(stt_pkg::INV_GAIN))
                   + (((rot_lo[31:0] * 64'(stt_pkg::INV_GAIN)) + 64'h80000000) >> 32)
                   + ((64'(rot_lo[63:32]) * 64'(stt_pkg::INV_GAIN)));

  assign rinc_x = (x_r + WW'(1 << (G - 1))) >>> G;
  assign rinc_y = (y_r + WW'(1 << (G - 1))) >>> G;
  assign sx = (WW+1)'(posx_r) + (WW+1)'(rinc_x);
  assign sy = (WW+1)'(posy_r) + (WW+1)'(rinc_y);

  function automatic logic [31:0] sat32(input logic signed [WW:0] v);
    logic [31:0] r;
    if (v > (WW+1)'(32'sh7FFFFFFF)) r = 32'h7FFFFFFF;
    else if (v < -(WW+1)'(33'sh80000000)) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Position state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      posx_r <= '0;
      posy_r <= '0;
    end else if (cmd.finish) begin
      if (load_r || arr_r) begin
        posx_r <= tx_r;
        posy_r <= ty_r;
      end else begin
        posx_r <= sat32(sx);
        posy_r <= sat32(sy);
      end
    end
  end

  // Item latch, CORDIC iterations and result fields
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      load_r <= (in_op == stt_pkg::OP_LOAD);
      tx_r   <= in_target_x;
      ty_r   <= in_target_y;
      amt_r  <= in_step_amount;
      z_r    <= '0;
      arr_r  <= 1'b1;
      near_r <= 1'b1;
      gap_r  <= '0;
      head_r <= '0;
    end
    if (cmd.vec_step) begin
      if (iter == 5'd0) begin
        // fold left half plane, then first iteration on folded vector
        if (xg < 0) begin
          x_r <= -xg + ((-yg >= 0) ? (-yg) : yg);
          y_r <= (-yg >= 0) ? (-yg + xg) : (-yg - xg);
          z_r <= 32'h80000000 + ((-yg >= 0) ? at : -at);
        end else begin
          x_r <= xg + ((yg >= 0) ? yg : -yg);
          y_r <= (yg >= 0) ? (yg - xg) : (yg + xg);
          z_r <= (yg >= 0) ? at : -at;
        end
      end else if (y_r >= 0) begin
        x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + at;
      end else begin
        x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - at;
      end
    end
    if (cmd.mag) begin
      if (dx == 0 && dy == 0) begin
        gap_r  <= '0;
        head_r <= '0;
        z_r    <= '0;
        near_r <= (32'd0 < near_threshold);
        arr_r  <= (34'd0 < 34'(amt_r));
      end else begin
        gap_r  <= mag_dist[33:32] != 2'd0 ? 32'hFFFFFFFF : mag_dist[31:0];
        head_r <= 16'((z_r + 32'h8000) >> 16);
        near_r <= ((mag_dist[33:32] != 2'd0 ? 32'hFFFFFFFF : mag_dist[31:0]) < near_threshold);
        arr_r  <= (mag_dist < 34'(amt_r));
      end
    end
    if (cmd.rot_init) begin
      if (z_r[31:30] == 2'd1 || z_r[31:30] == 2'd2) begin
        x_r  <= -WW'(rot_mag);
        za_r <= z_r - 32'h80000000;
      end else begin
        x_r  <= WW'(rot_mag);
        za_r <= z_r;
      end
      y_r <= '0;
    end
    if (cmd.rot_step) begin
      if (za_r[31]) begin
        x_r <= x_r + ys; y_r <= y_r - xs; za_r <= za_r + at;
      end else begin
        x_r <= x_r - ys; y_r <= y_r + xs; za_r <= za_r - at;
      end
    end
  end

  assign sts.is_load = load_r;
  assign sts.arrived = arr_r;
  assign pos_x   = posx_r;
  assign pos_y   = posy_r;
  assign arrived = arr_r;
  assign gap     = gap_r;
  assign heading = head_r;
  assign near    = near_r;

endmodule

[rtl/step_toward_target.sv]
// step_toward_target: moves a 2-D Q16.16 point toward a target.
// Channels: in (op, target_x, target_y, step_amount) and out (pos_x, pos_y,
// arrived, gap, heading, near), valid/ready; one result per transaction.
// Config: APB-style port, register near_threshold at address 0 (reset 3277).
// Sequence: a load skips the CORDIC; a step runs a vectoring pass, then
// either snaps to the target or runs a rotation pass, both passes on
// one shared CORDIC iterated once per cycle for vectoring and rotation.
// One transaction is in flight at a time; in_ready is high only when idle.
// Reset (synchronous, rst_n low) puts the position at the origin.
// While out_ready is low the result is held and no new input is taken.
// Depends on stt_pkg, stt_if, stt_ctrl, stt_dp.
module step_toward_target #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  stt_in_if.sink      in_ch,
  stt_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  stt_pkg::cmd_t cmd;
  stt_pkg::sts_t sts;
  logic [4:0]    iter;
  logic [31:0]   near_thr_r;

  // Config register write
  always_ff @(posedge clk) begin
    if (!rst_n) near_thr_r <= 32'd3277;
    else if (cfg_psel && cfg_penable && cfg_pwrite &&
             cfg_paddr[1:1] == stt_pkg::REG_NEAR && cfg_paddr[0] == 1'b0)
      near_thr_r <= cfg_pwdata;
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? near_thr_r : 32'd0;

  stt_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .iter, .sts
  );

  stt_dp u_dp (
    .clk, .rst_n, .cmd, .iter, .sts,
    .near_threshold(near_thr_r),
    .in_op(in_ch.op), .in_target_x(in_ch.target_x),
    .in_target_y(in_ch.target_y), .in_step_amount(in_ch.step_amount),
    .pos_x(out_ch.pos_x), .pos_y(out_ch.pos_y), .arrived(out_ch.arrived),
    .gap(out_ch.gap), .heading(out_ch.heading), .near(out_ch.near)
  );

endmodule
